[rtl/adc7s_pkg.sv]
`timescale 1ns / 1ps
package adc7s_pkg;

    localparam int ADC_BITS_DEF    = 10;
    localparam int NUM_W           = 16;
    localparam int OFF_W           = 8;
    localparam int CFG_W           = 16;
    // quotient bits resolved per divider stage
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = NUM_W / STEPS_PER_STAGE;
    localparam int FRAMES          = 4;
    localparam int FRAME_IDX_W     = $clog2(FRAMES);
    localparam int VAL_W           = 7;
    localparam int DIGIT_W         = 4;
    localparam int MAX_SHOWN       = 99;

    localparam logic [NUM_W-1:0] SCALE_NUM_RST  = 16'd6144;
    localparam logic [OFF_W-1:0] RES_OFFSET_RST = 8'd10;

    localparam logic [7:0] DIGIT_SEL_LAST = 8'hFB;

    typedef enum logic [0:0] {
        CFG_SCALE_NUM  = 1'b0,
        CFG_RES_OFFSET = 1'b1
    } t_cfg_idx;

    // one byte per frame, frame 0 in the low byte
    typedef logic [FRAMES-1:0][7:0] t_pat_set;

    typedef struct packed {
        logic valid;
    } t_hs;

    function automatic logic [7:0] seg_normal(input logic [DIGIT_W-1:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'h3F;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5B;
            4'd3:    p = 8'h4F;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6D;
            4'd6:    p = 8'h7D;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7F;
            4'd9:    p = 8'h6F;
            default: p = 8'h3F;
        endcase
        return p;
    endfunction

    // mirrored glyphs for the upside-down digit pair
    function automatic logic [7:0] seg_flipped(input logic [DIGIT_W-1:0] d);
        logic [7:0] p;
        case (d)
            4'd0:    p = 8'h3F;
            4'd1:    p = 8'h30;
            4'd2:    p = 8'h5B;
            4'd3:    p = 8'h79;
            4'd4:    p = 8'h74;
            4'd5:    p = 8'h6D;
            4'd6:    p = 8'h6F;
            4'd7:    p = 8'h3C;
            4'd8:    p = 8'h7F;
            4'd9:    p = 8'h7D;
            default: p = 8'h3F;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] digit_enable(input logic [FRAME_IDX_W-1:0] k);
        logic [7:0] e;
        case (k)
            2'd0:    e = 8'hFE;
            2'd1:    e = 8'hFD;
            2'd2:    e = 8'hF7;
            2'd3:    e = DIGIT_SEL_LAST;
            default: e = 8'hFE;
        endcase
        return e;
    endfunction

endpackage

[rtl/adc7s_div_stage.sv]
`timescale 1ns / 1ps
module adc7s_div_stage #(
    parameter int ADC_BITS = adc7s_pkg::ADC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  adc7s_pkg::t_hs              i_up,
    input  logic [ADC_BITS:0]           i_rem,
    input  logic [adc7s_pkg::NUM_W-1:0] i_acc,
    input  logic [ADC_BITS-1:0]         i_dvs,
    input  logic                        i_dn_ready,
    output logic                        o_ready,
    output logic                        o_valid,
    output logic [ADC_BITS:0]           o_rem,
    output logic [adc7s_pkg::NUM_W-1:0] o_acc,
    output logic [ADC_BITS-1:0]         o_dvs
);

    logic                        r_valid;
    logic [ADC_BITS:0]           r_rem;
    logic [adc7s_pkg::NUM_W-1:0] r_acc;
    logic [ADC_BITS-1:0]         r_dvs;
    logic [ADC_BITS:0]           n_rem;
    logic [adc7s_pkg::NUM_W-1:0] n_acc;

    assign o_ready = !r_valid || i_dn_ready;

    // restoring division: acc shifts the dividend out and the quotient in
    always_comb begin
        n_rem = i_rem;
        n_acc = i_acc;
        for (int s = 0; s < adc7s_pkg::STEPS_PER_STAGE; s++) begin
            n_rem = {n_rem[ADC_BITS-1:0], n_acc[adc7s_pkg::NUM_W-1]};
            n_acc = {n_acc[adc7s_pkg::NUM_W-2:0], 1'b0};
            if (n_rem >= {1'b0, i_dvs}) begin
                n_rem    = n_rem - {1'b0, i_dvs};
                n_acc[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_up.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_up.valid) begin
            r_rem <= n_rem;
            r_acc <= n_acc;
            r_dvs <= i_dvs;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_acc   = r_acc;
    assign o_dvs   = r_dvs;

endmodule

[rtl/adc7s_digits.sv]
`timescale 1ns / 1ps
module adc7s_digits #(
    parameter int ADC_BITS = adc7s_pkg::ADC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  adc7s_pkg::t_hs              i_up,
    input  logic [adc7s_pkg::NUM_W-1:0] i_quot,
    input  logic [ADC_BITS-1:0]         i_dvs,
    input  logic [adc7s_pkg::OFF_W-1:0] i_offset,
    input  logic                        i_dn_ready,
    output logic                        o_ready,
    output logic                        o_valid,
    output adc7s_pkg::t_pat_set         o_pats
);

    localparam logic [adc7s_pkg::NUM_W-1:0] MAX_Q = adc7s_pkg::NUM_W'(adc7s_pkg::MAX_SHOWN);

    logic                          r_a_valid;
    logic [adc7s_pkg::VAL_W-1:0]   r_val;
    logic                          r_b_valid;
    adc7s_pkg::t_pat_set           r_pats;
    logic                          w_ready_b;
    logic [adc7s_pkg::VAL_W-1:0]   n_val;
    logic [adc7s_pkg::NUM_W-1:0]   w_diff;
    logic [14:0]                   w_prod;
    logic [adc7s_pkg::DIGIT_W-1:0] w_tens;
    logic [adc7s_pkg::VAL_W-1:0]   w_ones_full;
    logic [adc7s_pkg::DIGIT_W-1:0] w_ones;
    adc7s_pkg::t_pat_set           n_pats;

    assign w_ready_b = !r_b_valid || i_dn_ready;
    assign o_ready   = !r_a_valid || w_ready_b;

    // stage A: zero sample, offset and clamp to 0..99
    assign w_diff = i_quot - {{(adc7s_pkg::NUM_W-adc7s_pkg::OFF_W){1'b0}}, i_offset};
    always_comb begin
        if (i_dvs == '0 ||
            i_quot <= {{(adc7s_pkg::NUM_W-adc7s_pkg::OFF_W){1'b0}}, i_offset}) begin
            n_val = '0;
        end else if (w_diff > MAX_Q) begin
            n_val = adc7s_pkg::VAL_W'(adc7s_pkg::MAX_SHOWN);
        end else begin
            n_val = w_diff[adc7s_pkg::VAL_W-1:0];
        end
    end

    // stage B: tens = v*205 >> 11 is exact for v below 100
    assign w_prod      = {8'b0, r_val} * 15'd205;
    assign w_tens      = w_prod[14:11];
    assign w_ones_full = r_val - ({3'b0, w_tens} * 7'd10);
    assign w_ones      = w_ones_full[adc7s_pkg::DIGIT_W-1:0];

    always_comb begin
        n_pats[0] = adc7s_pkg::seg_normal(w_tens);
        n_pats[1] = adc7s_pkg::seg_normal(w_ones);
        n_pats[2] = adc7s_pkg::seg_flipped(w_tens);
        n_pats[3] = adc7s_pkg::seg_flipped(w_ones);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_valid <= i_up.valid;
            end
            if (w_ready_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_up.valid) begin
            r_val <= n_val;
        end
        if (w_ready_b && r_a_valid) begin
            r_pats <= n_pats;
        end
    end

    assign o_valid = r_b_valid;
    assign o_pats  = r_pats;

endmodule

[rtl/adc7s_frame_out.sv]
`timescale 1ns / 1ps
module adc7s_frame_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  adc7s_pkg::t_hs      i_up,
    input  adc7s_pkg::t_pat_set i_pats,
    input  logic                i_stall,
    output logic                o_ready,
    output logic                o_valid,
    output logic [7:0]          o_digit_select,
    output logic [7:0]          o_segment_pattern,
    output logic                o_last_frame
);

    localparam logic [adc7s_pkg::FRAME_IDX_W-1:0] LAST_IDX =
        adc7s_pkg::FRAME_IDX_W'(adc7s_pkg::FRAMES - 1);

    logic                                r_busy;
    logic [adc7s_pkg::FRAME_IDX_W-1:0]   r_idx;
    adc7s_pkg::t_pat_set                 r_pats;
    logic                                w_take;
    logic                                w_load;

    assign w_take  = r_busy && !i_stall;
    assign o_ready = !r_busy || (w_take && r_idx == LAST_IDX);
    assign w_load  = o_ready && i_up.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_take) begin
            r_busy <= (r_idx != LAST_IDX);
            r_idx  <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_pats <= i_pats;
        end
    end

    assign o_valid           = r_busy;
    assign o_digit_select    = adc7s_pkg::digit_enable(r_idx);
    assign o_segment_pattern = r_pats[r_idx];
    assign o_last_frame      = (r_idx == LAST_IDX);

endmodule

[rtl/adc_to_seven_segment_frames.sv]
`timescale 1ns / 1ps
// ADC sample to two-digit seven-segment display frames.
// Input channel: i_adc_valid / o_adc_stall carry one ADC_BITS-wide sample per beat.
// Output channel: o_frame_valid / i_frame_stall carry display frames; each sample
// yields four beats (digit select FE, FD, F7, FB) with o_last_frame on the fourth.
// Shown value: floor(scale_numerator / sample) - resistance_offset, clamped to
// 0..99; a zero sample shows 0.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_index (0: numerator,
// 1: offset, low 8 bits); write only while no sample is in flight.
// The sample passes through 8 divider stages of two quotient bits each, a clamp
// stage and a digit/lookup stage on its way to the frame serializer.
// The single frame serializer sets the sample rate; it sends one frame per cycle
// while i_frame_stall is low, and up to 11 samples may be buffered in the pipeline.
// Reset (synchronous, active low) empties the pipeline and restores the
// registers to 6144 and 10.
// When i_frame_stall is high the current frame holds; the pipeline keeps
// filling its empty stages and raises o_adc_stall once it is full.
module adc_to_seven_segment_frames #(
    parameter int ADC_BITS = adc7s_pkg::ADC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adc_valid,
    output logic                        o_adc_stall,
    input  logic [ADC_BITS-1:0]         i_adc_sample,
    output logic                        o_frame_valid,
    input  logic                        i_frame_stall,
    output logic [7:0]                  o_digit_select,
    output logic [7:0]                  o_segment_pattern,
    output logic                        o_last_frame,
    input  logic                        i_cfg_we,
    input  adc7s_pkg::t_cfg_idx         i_cfg_index,
    input  logic [adc7s_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int N = adc7s_pkg::DIV_STAGES;

    logic [adc7s_pkg::NUM_W-1:0] r_scale_num;
    logic [adc7s_pkg::OFF_W-1:0] r_res_offset;

    logic                        w_valid [0:N];
    logic                        w_ready [0:N];
    logic [ADC_BITS:0]           w_rem   [0:N];
    logic [adc7s_pkg::NUM_W-1:0] w_acc   [0:N];
    logic [ADC_BITS-1:0]         w_dvs   [0:N];

    logic                        w_dig_valid;
    logic                        w_out_ready;
    adc7s_pkg::t_pat_set         w_pats;
    adc7s_pkg::t_hs              w_dig_hs;
    adc7s_pkg::t_hs              w_out_hs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_num  <= adc7s_pkg::SCALE_NUM_RST;
            r_res_offset <= adc7s_pkg::RES_OFFSET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                adc7s_pkg::CFG_SCALE_NUM:  r_scale_num  <= i_cfg_data[adc7s_pkg::NUM_W-1:0];
                adc7s_pkg::CFG_RES_OFFSET: r_res_offset <= i_cfg_data[adc7s_pkg::OFF_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_valid[0] = i_adc_valid;
    assign w_rem[0]   = '0;
    assign w_acc[0]   = r_scale_num;
    assign w_dvs[0]   = i_adc_sample;
    assign o_adc_stall = !w_ready[0];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_div
            adc7s_pkg::t_hs w_hs;
            assign w_hs.valid = w_valid[k];
            adc7s_div_stage #(
                .ADC_BITS (ADC_BITS)
            ) u_stage (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_up       (w_hs),
                .i_rem      (w_rem[k]),
                .i_acc      (w_acc[k]),
                .i_dvs      (w_dvs[k]),
                .i_dn_ready (w_ready[k+1]),
                .o_ready    (w_ready[k]),
                .o_valid    (w_valid[k+1]),
                .o_rem      (w_rem[k+1]),
                .o_acc      (w_acc[k+1]),
                .o_dvs      (w_dvs[k+1])
            );
        end
    endgenerate

    assign w_dig_hs.valid = w_valid[N];

    adc7s_digits #(
        .ADC_BITS (ADC_BITS)
    ) u_digits (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up       (w_dig_hs),
        .i_quot     (w_acc[N]),
        .i_dvs      (w_dvs[N]),
        .i_offset   (r_res_offset),
        .i_dn_ready (w_out_ready),
        .o_ready    (w_ready[N]),
        .o_valid    (w_dig_valid),
        .o_pats     (w_pats)
    );

    assign w_out_hs.valid = w_dig_valid;

    adc7s_frame_out u_frame_out (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_up              (w_out_hs),
        .i_pats            (w_pats),
        .i_stall           (i_frame_stall),
        .o_ready           (w_out_ready),
        .o_valid           (o_frame_valid),
        .o_digit_select    (o_digit_select),
        .o_segment_pattern (o_segment_pattern),
        .o_last_frame      (o_last_frame)
    );

`ifndef ASSERT_OFF
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_frame_valid)
        else $error("frame valid right after reset");

    a_run_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_valid && !i_frame_stall && !o_last_frame |=> o_frame_valid)
        else $error("frame run broken before its last frame");

    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_valid && o_last_frame |-> o_digit_select == adc7s_pkg::DIGIT_SEL_LAST)
        else $error("last frame not on the final digit");

    a_seg_nonblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_valid |-> o_segment_pattern != 8'h00)
        else $error("blank segment pattern");
`endif

endmodule
